// ===== design/rrsi_pkg.sv =====
// Shared types, codes and defaults for the round-robin stream interleaver.
// No dependencies; imported by every module of the block.
`default_nettype none

package rrsi_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_STREAMS_DEF  = 8;
   localparam int STREAM_DEPTH_DEF = 64;

   // Fixed field widths
   localparam int DATA_W   = 32;
   localparam int STRM_W   = 3;
   localparam int NUM_W    = 4;
   localparam int STATUS_W = 2;

   // Request kinds
   localparam logic REQ_APPEND = 1'b0;
   localparam logic REQ_NEXT   = 1'b1;

   // Reset value of the rotation size register
   localparam logic [NUM_W-1:0] NUM_STREAMS_RST = 4'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_APPENDED  = 2'd0,
      ST_DELIVERED = 2'd1,
      ST_EXHAUSTED = 2'd2,
      ST_DROPPED   = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE    = 1'b0,
      S_DELIVER = 1'b1
   } fsm_type;

   // Result of the rotating search
   typedef struct packed {
      logic              found;
      logic [STRM_W-1:0] idx;
   } grant_type;

   // Effective rotation size: zero acts as one, clamp to the stream count
   function automatic logic [NUM_W-1:0] active_count(input logic [NUM_W-1:0] raw,
                                                     input logic [NUM_W-1:0] max_n);
      logic [NUM_W-1:0] n;
      n = raw;
      if (n == '0) n = NUM_W'(1);
      if (n > max_n) n = max_n;
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== design/rrsi_arbiter.sv =====
// Rotating priority search over the per-stream pending flags.
// Depends on rrsi_pkg.
`default_nettype none

module rrsi_arbiter #(
   parameter int MAX_STREAMS = rrsi_pkg::MAX_STREAMS_DEF
) (
   input  wire logic [MAX_STREAMS-1:0]    pending,
   input  wire logic [rrsi_pkg::STRM_W-1:0] start,
   input  wire logic [rrsi_pkg::NUM_W-1:0]  count,
   output rrsi_pkg::grant_type            grant
);
   import rrsi_pkg::*;

   localparam int IDX_W = $clog2(MAX_STREAMS);

   always_comb begin
      logic [NUM_W-1:0] cand;
      grant = '0;
      for (int k = 0; k < MAX_STREAMS; k++) begin
         // wrap within the rotation; start < count so one subtract suffices
         cand = NUM_W'(start) + NUM_W'(k);
         if (cand >= count) cand = cand - count;
         if ((NUM_W'(k) < count) && !grant.found && pending[cand[IDX_W-1:0]]) begin
            grant.found = 1'b1;
            grant.idx   = cand[STRM_W-1:0];
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/round_robin_stream_interleaver.sv =====
// Top level of the round-robin stream interleaver: counters, value memory,
// control sequencer and response register. Depends on rrsi_pkg, rrsi_arbiter.
`default_nettype none

// The block holds up to MAX_STREAMS FIFO streams of 32-bit values, each with
// room for STREAM_DEPTH values over its lifetime (space is never reclaimed).
// An append request stores req_data_in at the end of stream req_stream_sel,
// or drops it with status 3 when that stream is full or out of range. A next
// request walks the rotation (streams 0 .. num_streams-1) starting after the
// stream last served and returns the oldest unread value of the first stream
// that has one (status 1, with its stream number), or status 2 when all are
// exhausted. Every request yields exactly one response, in order. In the
// accept cycle of a request the counters are updated and the value memory
// is written or read; afterwards the memory's registered read data is moved
// into the response register once that register is free. A new request is
// taken once that move has happened, even while the response still waits
// for rsp_ready. The value memory needs no clearing after reset. Write
// csr_num_streams only while the block is idle; it also restarts the
// rotation at stream 0.

module round_robin_stream_interleaver #(
   parameter int MAX_STREAMS  = rrsi_pkg::MAX_STREAMS_DEF,
   parameter int STREAM_DEPTH = rrsi_pkg::STREAM_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_type,
   input  wire logic [rrsi_pkg::STRM_W-1:0]   req_stream_sel,
   input  wire logic [rrsi_pkg::DATA_W-1:0]   req_data_in,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [rrsi_pkg::STATUS_W-1:0]      rsp_status,
   output logic [rrsi_pkg::DATA_W-1:0]        rsp_data_out,
   output logic [rrsi_pkg::STRM_W-1:0]        rsp_src_stream,
   // configuration channel
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [rrsi_pkg::NUM_W-1:0]    csr_num_streams
);
   import rrsi_pkg::*;

   localparam int IDX_W  = $clog2(MAX_STREAMS);
   localparam int CNT_W  = $clog2(STREAM_DEPTH + 1);
   localparam int DEPTH  = MAX_STREAMS * STREAM_DEPTH;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [NUM_W-1:0] MAX_N     = NUM_W'(MAX_STREAMS);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(STREAM_DEPTH);

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   fsm_type              state_ff, state_in;
   logic [NUM_W-1:0]     num_streams_ff, num_streams_in;
   logic [STRM_W-1:0]    last_served_ff, last_served_in;
   logic [CNT_W-1:0]     wr_cnt_ff [MAX_STREAMS];
   logic [CNT_W-1:0]     wr_cnt_in [MAX_STREAMS];
   logic [CNT_W-1:0]     rd_pos_ff [MAX_STREAMS];
   logic [CNT_W-1:0]     rd_pos_in [MAX_STREAMS];

   // result of the accepted request, waiting for the memory read data
   status_type           pend_status_ff, pend_status_in;
   logic [STRM_W-1:0]    pend_src_ff, pend_src_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [STRM_W-1:0]    rsp_src_ff, rsp_src_in;

   // value memory, registered read data
   logic [DATA_W-1:0]    value_mem [DEPTH];
   logic [DATA_W-1:0]    mem_q_ff;
   logic                 mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0]    mem_wr_addr, mem_rd_addr;

   // ---------------------------------------------------------------------
   // Handshakes
   // ---------------------------------------------------------------------
   logic req_accept, csr_accept, load_rsp;

   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;
   assign req_accept = req_valid && req_ready;

   // ---------------------------------------------------------------------
   // Rotation search
   // ---------------------------------------------------------------------
   logic [NUM_W-1:0]       active_n;
   logic [STRM_W-1:0]      start;
   logic [MAX_STREAMS-1:0] pending;
   grant_type              grant;

   assign active_n = active_count(num_streams_ff, MAX_N);

   always_comb begin
      // begin after the stream last served, wrapping at the rotation size
      if (NUM_W'(last_served_ff) < active_n) begin
         if (NUM_W'(last_served_ff) + NUM_W'(1) >= active_n) start = '0;
         else start = last_served_ff + STRM_W'(1);
      end else begin
         start = '0;
      end
      for (int i = 0; i < MAX_STREAMS; i++) begin
         pending[i] = rd_pos_ff[i] < wr_cnt_ff[i];
      end
   end

   rrsi_arbiter #(
      .MAX_STREAMS (MAX_STREAMS)
   ) u_arbiter (
      .pending (pending),
      .start   (start),
      .count   (active_n),
      .grant   (grant)
   );

   // ---------------------------------------------------------------------
   // Request execution: counters, memory access, pending result
   // ---------------------------------------------------------------------
   logic             sel_ok;
   logic [IDX_W-1:0] sel_idx, grant_idx;

   assign sel_idx   = req_stream_sel[IDX_W-1:0];
   assign grant_idx = grant.idx[IDX_W-1:0];
   assign sel_ok    = (NUM_W'(req_stream_sel) < MAX_N) && (wr_cnt_ff[sel_idx] < FULL_CNT);

   always_comb begin
      for (int i = 0; i < MAX_STREAMS; i++) begin
         wr_cnt_in[i] = wr_cnt_ff[i];
         rd_pos_in[i] = rd_pos_ff[i];
      end
      last_served_in = last_served_ff;
      pend_status_in = pend_status_ff;
      pend_src_in    = pend_src_ff;
      mem_wr_en      = 1'b0;
      mem_rd_en      = 1'b0;
      mem_wr_addr    = ADDR_W'(sel_idx) * ADDR_W'(STREAM_DEPTH)
                       + ADDR_W'(wr_cnt_ff[sel_idx]);
      mem_rd_addr    = ADDR_W'(grant_idx) * ADDR_W'(STREAM_DEPTH)
                       + ADDR_W'(rd_pos_ff[grant_idx]);

      if (req_accept) begin
         pend_src_in = '0;
         if (req_type == REQ_APPEND) begin
            if (sel_ok) begin
               // store at the tail and advance the write count
               mem_wr_en          = 1'b1;
               wr_cnt_in[sel_idx] = wr_cnt_ff[sel_idx] + CNT_W'(1);
               pend_status_in     = ST_APPENDED;
            end else begin
               pend_status_in     = ST_DROPPED;
            end
         end else if (grant.found) begin
            // fetch the oldest unread value and advance the read position
            mem_rd_en            = 1'b1;
            rd_pos_in[grant_idx] = rd_pos_ff[grant_idx] + CNT_W'(1);
            last_served_in       = grant.idx;
            pend_status_in       = ST_DELIVERED;
            pend_src_in          = grant.idx;
         end else begin
            // nothing pending: still step the rotation by one
            last_served_in = start;
            pend_status_in = ST_EXHAUSTED;
         end
      end

      // a rotation size write restarts the rotation at stream 0
      num_streams_in = num_streams_ff;
      if (csr_accept) begin
         num_streams_in = csr_num_streams;
         last_served_in = STRM_W'(active_count(csr_num_streams, MAX_N) - NUM_W'(1));
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (req_accept) state_in = S_DELIVER;
         S_DELIVER: if (load_rsp)   state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         S_IDLE:    req_ready = 1'b1;
         S_DELIVER: load_rsp  = !rsp_valid_ff || rsp_ready;
         default:   req_ready = 1'b0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Response register: hold until taken, load when free
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_src_in    = rsp_src_ff;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = pend_status_ff;
         rsp_src_in    = pend_src_ff;
         rsp_data_in   = (pend_status_ff == ST_DELIVERED) ? mem_q_ff : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_src_stream = rsp_src_ff;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         num_streams_ff <= NUM_STREAMS_RST;
         last_served_ff <= STRM_W'(active_count(NUM_STREAMS_RST, MAX_N) - NUM_W'(1));
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < MAX_STREAMS; i++) begin
            wr_cnt_ff[i] <= '0;
            rd_pos_ff[i] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         num_streams_ff <= num_streams_in;
         last_served_ff <= last_served_in;
         rsp_valid_ff   <= rsp_valid_in;
         for (int i = 0; i < MAX_STREAMS; i++) begin
            wr_cnt_ff[i] <= wr_cnt_in[i];
            rd_pos_ff[i] <= rd_pos_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      pend_src_ff    <= pend_src_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_src_ff     <= rsp_src_in;
   end

   // value memory
   always_ff @(posedge clock) begin
      if (mem_wr_en) value_mem[mem_wr_addr] <= req_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_rd_en) mem_q_ff <= value_mem[mem_rd_addr];
   end

endmodule

`default_nettype wire
